/* src/nls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nls_pkg: shared types and constants of the natural log series core
// Fixed-point constants, reciprocal table, controller command codes and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package nls_pkg;

  // number of series terms (1..64)
  localparam int TERMS = 32;

  localparam int VALUE_W = 32;
  localparam int LOG_W   = 21;
  localparam int K_W     = 7;   // holds 1..64
  localparam int CNT_W   = 5;   // reduction count stays within -12..11

  localparam logic [31:0] ONE_Q16     = 32'd65536;
  localparam logic [31:0] QUARTER_Q16 = 32'd16384;
  localparam logic [31:0] E_Q16       = 32'd178145;

  // floor(2^47 / e_q16): x * RECIP_E >> 31 is floor((x << 16) / e_q16) or one below
  localparam logic [31:0] RECIP_E = 32'(64'd140737488355328 / 64'd178145);

  localparam logic signed [24:0] LOG_MAX = 25'sd1048575;
  localparam logic signed [24:0] LOG_MIN = -25'sd1048576;

  // floor((2^32 - 1) / k) for k = 1..64, entry k-1
  localparam logic [31:0] RECIP_K [64] = '{
    32'hFFFFFFFF / 32'd1,  32'hFFFFFFFF / 32'd2,  32'hFFFFFFFF / 32'd3,  32'hFFFFFFFF / 32'd4,
    32'hFFFFFFFF / 32'd5,  32'hFFFFFFFF / 32'd6,  32'hFFFFFFFF / 32'd7,  32'hFFFFFFFF / 32'd8,
    32'hFFFFFFFF / 32'd9,  32'hFFFFFFFF / 32'd10, 32'hFFFFFFFF / 32'd11, 32'hFFFFFFFF / 32'd12,
    32'hFFFFFFFF / 32'd13, 32'hFFFFFFFF / 32'd14, 32'hFFFFFFFF / 32'd15, 32'hFFFFFFFF / 32'd16,
    32'hFFFFFFFF / 32'd17, 32'hFFFFFFFF / 32'd18, 32'hFFFFFFFF / 32'd19, 32'hFFFFFFFF / 32'd20,
    32'hFFFFFFFF / 32'd21, 32'hFFFFFFFF / 32'd22, 32'hFFFFFFFF / 32'd23, 32'hFFFFFFFF / 32'd24,
    32'hFFFFFFFF / 32'd25, 32'hFFFFFFFF / 32'd26, 32'hFFFFFFFF / 32'd27, 32'hFFFFFFFF / 32'd28,
    32'hFFFFFFFF / 32'd29, 32'hFFFFFFFF / 32'd30, 32'hFFFFFFFF / 32'd31, 32'hFFFFFFFF / 32'd32,
    32'hFFFFFFFF / 32'd33, 32'hFFFFFFFF / 32'd34, 32'hFFFFFFFF / 32'd35, 32'hFFFFFFFF / 32'd36,
    32'hFFFFFFFF / 32'd37, 32'hFFFFFFFF / 32'd38, 32'hFFFFFFFF / 32'd39, 32'hFFFFFFFF / 32'd40,
    32'hFFFFFFFF / 32'd41, 32'hFFFFFFFF / 32'd42, 32'hFFFFFFFF / 32'd43, 32'hFFFFFFFF / 32'd44,
    32'hFFFFFFFF / 32'd45, 32'hFFFFFFFF / 32'd46, 32'hFFFFFFFF / 32'd47, 32'hFFFFFFFF / 32'd48,
    32'hFFFFFFFF / 32'd49, 32'hFFFFFFFF / 32'd50, 32'hFFFFFFFF / 32'd51, 32'hFFFFFFFF / 32'd52,
    32'hFFFFFFFF / 32'd53, 32'hFFFFFFFF / 32'd54, 32'hFFFFFFFF / 32'd55, 32'hFFFFFFFF / 32'd56,
    32'hFFFFFFFF / 32'd57, 32'hFFFFFFFF / 32'd58, 32'hFFFFFFFF / 32'd59, 32'hFFFFFFFF / 32'd60,
    32'hFFFFFFFF / 32'd61, 32'hFFFFFFFF / 32'd62, 32'hFFFFFFFF / 32'd63, 32'hFFFFFFFF / 32'd64
  };

  // datapath commands
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_DIV_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV_QE   = 4'd3;
  localparam logic [3:0] OP_DIV_FIX  = 4'd4;
  localparam logic [3:0] OP_EXP_MUL  = 4'd5;
  localparam logic [3:0] OP_EXP_TAKE = 4'd6;
  localparam logic [3:0] OP_SER_INIT = 4'd7;
  localparam logic [3:0] OP_SER_R    = 4'd8;
  localparam logic [3:0] OP_SER_K    = 4'd9;
  localparam logic [3:0] OP_SER_ACC  = 4'd10;
  localparam logic [3:0] OP_EMIT     = 4'd11;

  typedef struct packed {
    logic [3:0] op;
  } nls_cmd_t;

  typedef struct packed {
    logic bad;         // operand zero or negative
    logic gt_one;      // x > 1.0
    logic lt_quarter;  // x < 0.25
    logic last_term;   // current term is the last one
    logic out_free;    // output register can take a word this cycle
  } nls_status_t;

endpackage
`default_nettype wire

/* src/nls_word_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nls_in_if / nls_out_if: valid/ready channels of the natural log core
// Input channel carries the Q16.16 operand; output channel the Q5.16 log
// and the invalid flag.
// ----------------------------------------------------------------------------
interface nls_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface nls_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] log_value;
  logic               invalid;

  modport source (output valid, output log_value, output invalid, input ready);
  modport sink (input valid, input log_value, input invalid, output ready);
endinterface
`default_nettype wire

/* src/nls_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nls_ctrl: sequencer of the natural log core
// Steps the datapath through range reduction, the series terms and the
// write of the result word.
// ----------------------------------------------------------------------------
module nls_ctrl
  import nls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire nls_status_t status,
  output nls_cmd_t         cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CHECK    = 4'd1;
  localparam logic [3:0] ST_DIV_A    = 4'd2;
  localparam logic [3:0] ST_DIV_B    = 4'd3;
  localparam logic [3:0] ST_DIV_C    = 4'd4;
  localparam logic [3:0] ST_EXP_A    = 4'd5;
  localparam logic [3:0] ST_EXP_B    = 4'd6;
  localparam logic [3:0] ST_SER_INIT = 4'd7;
  localparam logic [3:0] ST_SER_R    = 4'd8;
  localparam logic [3:0] ST_SER_K    = 4'd9;
  localparam logic [3:0] ST_SER_ACC  = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.bad) begin
          state_next = ST_DONE;
        end else if (status.gt_one) begin
          state_next = ST_DIV_A;
        end else if (status.lt_quarter) begin
          state_next = ST_EXP_A;
        end else begin
          state_next = ST_SER_INIT;
        end
      end
      ST_DIV_A: begin
        cmd.op     = OP_DIV_MUL;
        state_next = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd.op     = OP_DIV_QE;
        state_next = ST_DIV_C;
      end
      ST_DIV_C: begin
        cmd.op     = OP_DIV_FIX;
        state_next = ST_CHECK;
      end
      ST_EXP_A: begin
        cmd.op     = OP_EXP_MUL;
        state_next = ST_EXP_B;
      end
      ST_EXP_B: begin
        cmd.op     = OP_EXP_TAKE;
        state_next = ST_CHECK;
      end
      ST_SER_INIT: begin
        cmd.op     = OP_SER_INIT;
        state_next = ST_SER_R;
      end
      ST_SER_R: begin
        cmd.op     = OP_SER_R;
        state_next = ST_SER_K;
      end
      ST_SER_K: begin
        cmd.op     = OP_SER_K;
        state_next = ST_SER_ACC;
      end
      ST_SER_ACC: begin
        cmd.op     = OP_SER_ACC;
        state_next = status.last_term ? ST_DONE : ST_SER_R;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* src/nls_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nls_dp: datapath of the natural log core
// One shared 32x32 multiplier with a registered product serves the divide
// and multiply by e and the series terms; holds the output register.
// ----------------------------------------------------------------------------
module nls_dp
  import nls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire nls_cmd_t            cmd,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic signed [LOG_W-1:0]  out_log_value,
  output logic                     out_invalid,
  output nls_status_t              status
);

  logic [31:0]             x;
  logic signed [CNT_W-1:0] count;
  logic                    bad;
  logic [63:0]             prod;
  logic [31:0]             q0;
  logic [31:0]             p;
  logic [31:0]             a;
  logic [33:0]             s;
  logic [K_W-1:0]          k;

  logic [31:0]             mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             mul_p;
  logic [47:0]             div_rem;
  logic                    div_inc;
  logic [31:0]             ser_rem;
  logic                    ser_inc;
  logic [31:0]             a_new;
  logic [5:0]              k_idx;
  logic [18:0]             s16;
  logic signed [24:0]      res;
  logic signed [LOG_W-1:0] res_sat;

  assign k_idx = 6'(k - K_W'(1));
  assign a_new = {16'(ONE_Q16 - x), 16'h0000};

  always_comb begin
    mul_a = x;
    mul_b = E_Q16;
    case (cmd.op)
      OP_DIV_MUL: begin
        mul_a = x;
        mul_b = RECIP_E;
      end
      OP_DIV_QE: begin
        mul_a = prod[62:31];
        mul_b = E_Q16;
      end
      OP_EXP_MUL: begin
        mul_a = x;
        mul_b = E_Q16;
      end
      OP_SER_R: begin
        mul_a = prod[63:32];
        mul_b = RECIP_K[k_idx];
      end
      OP_SER_K: begin
        mul_a = prod[63:32];
        mul_b = 32'(k);
      end
      OP_SER_ACC: begin
        mul_a = p;
        mul_b = a;
      end
      default: begin
        mul_a = x;
        mul_b = E_Q16;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // correction of the reciprocal estimates: remainder below twice the divisor
  assign div_rem = {x[31:0], 16'h0000} - prod[47:0];
  assign div_inc = (div_rem >= 48'(E_Q16));
  assign ser_rem = p - prod[31:0];
  assign ser_inc = (ser_rem >= 32'(k));

  assign s16 = 19'((35'(s) + 35'd32768) >> 16);
  assign res = (25'(count) <<< 16) - $signed({6'b0, s16});

  always_comb begin
    if (res > LOG_MAX) begin
      res_sat = LOG_W'(LOG_MAX);
    end else if (res < LOG_MIN) begin
      res_sat = LOG_W'(LOG_MIN);
    end else begin
      res_sat = res[LOG_W-1:0];
    end
  end

  assign status.bad        = bad;
  assign status.gt_one     = (x > ONE_Q16);
  assign status.lt_quarter = (x < QUARTER_Q16);
  assign status.last_term  = (k == K_W'(TERMS));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x     <= in_value;
        bad   <= (in_value == '0) || in_value[VALUE_W-1];
        count <= '0;
      end
      OP_DIV_MUL: begin
        prod <= mul_p;
      end
      OP_DIV_QE: begin
        q0   <= prod[62:31];
        prod <= mul_p;
      end
      OP_DIV_FIX: begin
        x     <= q0 + 32'(div_inc);
        count <= count + CNT_W'(1);
      end
      OP_EXP_MUL: begin
        prod <= mul_p;
      end
      OP_EXP_TAKE: begin
        x     <= prod[47:16];
        count <= count - CNT_W'(1);
      end
      OP_SER_INIT: begin
        a    <= a_new;
        prod <= {a_new, 32'h0};
        s    <= '0;
        k    <= K_W'(1);
      end
      OP_SER_R: begin
        p    <= prod[63:32];
        prod <= mul_p;
      end
      OP_SER_K: begin
        q0   <= prod[63:32];
        prod <= mul_p;
      end
      OP_SER_ACC: begin
        s    <= s + 34'(q0) + 34'(ser_inc);
        prod <= mul_p;
        k    <= k + K_W'(1);
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_log_value <= bad ? '0 : res_sat;
      out_invalid   <= bad;
    end
  end

endmodule
`default_nettype wire

/* src/natural_log_series_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// natural_log_series_core: natural logarithm of a Q16.16 operand as Q5.16
// Range reduction by e, then a fixed number of terms of the log series,
// all on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//   channel   dir   payload                         word
//   in_word   in    value (s32, Q16.16)             one operand
//   out_word  out   log_value (s21, Q5.16), invalid one result per operand
//
// One operand at a time; in_word.ready is high only while idle.
// A zero or negative operand goes straight to the result; otherwise each
// word runs its divide-by-e steps, its multiply-by-e steps and TERMS series
// terms, all on the shared multiplier (three products per series term).
// A result waits in the output register; a new operand is taken meanwhile,
// and its result holds the sequencer until that register is free.
// Reset (rst, synchronous) clears the sequencer and the output valid only.
// ----------------------------------------------------------------------------
module natural_log_series_core
  import nls_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  nls_in_if.sink   in_word,
  nls_out_if.source out_word
);

  nls_cmd_t    cmd;
  nls_status_t status;

  nls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_word.valid),
    .in_ready (in_word.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nls_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_value      (in_word.value),
    .out_ready     (out_word.ready),
    .out_valid     (out_word.valid),
    .out_log_value (out_word.log_value),
    .out_invalid   (out_word.invalid),
    .status        (status)
  );

endmodule
`default_nettype wire
